// ===== hdl/ray_sphere_intersect_unit_defines.svh =====
// Assertion macros shared by the ray/sphere unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef RAY_SPHERE_INTERSECT_UNIT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check with reset masking
`define RSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers the reset cycles
`define RSI_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RSI_ASSERT(label, clk, rst, prop, msg)
`define RSI_ASSERT_NR(label, clk, prop, msg)

`endif

`endif

// ===== hdl/rsi_pkg.sv =====
// Types, constants and saturation helpers for the ray/sphere unit.
// No dependencies; used by every module of the unit but rsi_delay.
`default_nettype none

package rsi_pkg;

   localparam int Q_W        = 32;
   localparam int Q_FRAC     = 16;
   localparam int SQRT_IN_W  = 48;
   localparam int SQRT_OUT_W = 24;
   localparam int SQRT_LAT   = SQRT_OUT_W;
   localparam int DIV_N_W    = 49;
   localparam int DIV_D_W    = 31;
   localparam int DIV_LAT    = DIV_N_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIV_D_W-1:0] RADIUS_RESET = 31'd65536;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] t_low;
      logic signed [31:0] t_high;
   } req_type;

   typedef struct packed {
      logic               hit_found;
      logic signed [31:0] hit_distance;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic               front_face;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > SAT_HI) begin
         return 32'sh7fffffff;
      end else if (x < SAT_LO) begin
         return 32'sh80000000;
      end else begin
         return x[31:0];
      end
   endfunction

   // quotient magnitude with sign applied, clamped to 32 bits
   function automatic logic signed [31:0] sdiv_sat(input logic neg,
                                                   input logic [DIV_N_W-1:0] q);
      logic signed [65:0] sx;
      sx = $signed(66'(q));
      return sat32(neg ? -sx : sx);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rsi_delay.sv =====
// Delay line with valid bits, keeps side data aligned with the math units.
// Depends on nothing but its parameters.
`default_nettype none

module rsi_delay #(
   parameter int DEPTH = 1,
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_vld,
   output logic [WIDTH-1:0] out_data
);

   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         for (int i = DEPTH - 1; i > 0; i--) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = DEPTH - 1; i > 0; i--) begin
            data_ff[i] <= data_ff[i-1];
         end
         data_ff[0] <= in_data;
      end
   end

   assign out_vld  = vld_ff[DEPTH-1];
   assign out_data = data_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== hdl/rsi_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on rsi_pkg for widths and latency.
`default_nettype none

module rsi_sqrt_pipe (
   input  logic                            clock,
   input  logic                            en,
   input  logic [rsi_pkg::SQRT_IN_W-1:0]   radicand,
   output logic [rsi_pkg::SQRT_OUT_W-1:0]  root
);

   import rsi_pkg::*;

   logic [SQRT_IN_W-1:0] rem_ff [SQRT_LAT];
   logic [SQRT_IN_W-1:0] res_ff [SQRT_LAT];

   for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
      localparam logic [SQRT_IN_W-1:0] BIT = SQRT_IN_W'(1) << (SQRT_IN_W - 2 - 2 * k);
      logic [SQRT_IN_W-1:0] rem_prev, res_prev, trial, rem_in, res_in;

      if (k == 0) begin : g_first
         assign rem_prev = radicand;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[SQRT_LAT-1][SQRT_OUT_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/rsi_div_pipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rsi_pkg for widths and latency.
`default_nettype none

module rsi_div_pipe (
   input  logic                         clock,
   input  logic                         en,
   input  logic [rsi_pkg::DIV_N_W-1:0]  dividend,
   input  logic [rsi_pkg::DIV_D_W-1:0]  divisor,
   output logic [rsi_pkg::DIV_N_W-1:0]  quotient
);

   import rsi_pkg::*;

   logic [DIV_D_W-1:0] rem_ff [DIV_LAT];
   logic [DIV_N_W-1:0] num_ff [DIV_LAT];  // dividend bits out at top, quotient in at bottom
   logic [DIV_D_W-1:0] dvs_ff [DIV_LAT];

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
      logic [DIV_D_W-1:0] rem_prev, dvs_prev, rem_in;
      logic [DIV_N_W-1:0] num_prev, num_in;
      logic [DIV_D_W:0]   shifted;
      logic               ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = dividend;
         assign dvs_prev = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign dvs_prev = dvs_ff[k-1];
      end

      always_comb begin
         shifted = {rem_prev, num_prev[DIV_N_W-1]};
         ge      = shifted >= {1'b0, dvs_prev};
         rem_in  = ge ? DIV_D_W'(shifted - {1'b0, dvs_prev}) : shifted[DIV_D_W-1:0];
         num_in  = {num_prev[DIV_N_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= num_in;
            dvs_ff[k] <= dvs_prev;
         end
      end
   end

   assign quotient = num_ff[DIV_LAT-1];

endmodule

`default_nettype wire

// ===== hdl/ray_sphere_intersect_unit.sv =====
// Ray against sphere intersection, Q16.16 fixed point, fully pipelined.
// Depends on rsi_pkg, rsi_delay, rsi_sqrt_pipe, rsi_div_pipe and the defines header.
//
//   channel   ports                          moves
//   request   req_valid/req_ready/req_data   one ray per transfer
//   result    rsp_valid/rsp_ready/rsp_data   one result per ray
//   csr       csr_wr_en/csr_index/csr_wdata  sphere center and radius
//
// One ray enters per cycle while no finished result is held; each result passes
// through the 24-stage square root and two 49-stage division steps in series.
// Reset clears the valid bits and loads center 0, radius 1.0.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
`default_nettype none
`include "ray_sphere_intersect_unit_defines.svh"

module ray_sphere_intersect_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rsi_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rsi_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [rsi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rsi_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import rsi_pkg::*;

   typedef struct packed {
      logic               cand;
      logic signed [31:0] a;
      logic signed [31:0] hb;
      logic [2:0][31:0]   org;
      logic [2:0][31:0]   dir;
      logic signed [31:0] tlo;
      logic signed [31:0] thi;
   } sqd_type;

   typedef struct packed {
      logic               cand;
      logic               neg1;
      logic               neg2;
      logic [2:0][31:0]   org;
      logic [2:0][31:0]   dir;
      logic signed [31:0] tlo;
      logic signed [31:0] thi;
   } tdd_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] t;
      logic [2:0][31:0]   pt;
      logic [2:0][31:0]   dir;
      logic [2:0]         neg;
   } ndd_type;

   localparam int SQD_W = $bits(sqd_type);
   localparam int TDD_W = $bits(tdd_type);
   localparam int NDD_W = $bits(ndd_type);

   logic en;

   // ---------------- configuration ----------------
   logic signed [31:0]  cx_ff, cy_ff, cz_ff;
   logic [DIV_D_W-1:0]  rad_ff;
   logic signed [31:0]  ctr [3];
   logic [DIV_D_W-1:0]  r_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_CENTER_X: cx_ff  <= csr_wdata;
            CSR_CENTER_Y: cy_ff  <= csr_wdata;
            CSR_CENTER_Z: cz_ff  <= csr_wdata;
            CSR_RADIUS:   rad_ff <= csr_wdata[DIV_D_W-1:0];
            default: ;
         endcase
      end
   end

   assign ctr[0] = cx_ff;
   assign ctr[1] = cy_ff;
   assign ctr[2] = cz_ff;
   assign r_eff  = (rad_ff == '0) ? DIV_D_W'(1) : rad_ff;

   // ---------------- stage 1: oc = origin - center ----------------
   logic signed [31:0] req_org [3];
   logic signed [31:0] req_dir [3];
   logic               s1_vld_ff;
   logic signed [31:0] s1_org_ff [3], s1_dir_ff [3], s1_oc_ff [3];
   logic signed [31:0] s1_tlo_ff, s1_thi_ff;

   assign req_org[0] = req_data.origin_x;
   assign req_org[1] = req_data.origin_y;
   assign req_org[2] = req_data.origin_z;
   assign req_dir[0] = req_data.dir_x;
   assign req_dir[1] = req_data.dir_y;
   assign req_dir[2] = req_data.dir_z;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_org_ff[i] <= req_org[i];
            s1_dir_ff[i] <= req_dir[i];
            s1_oc_ff[i]  <= sat32(66'(req_org[i]) - 66'(ctr[i]));
         end
         s1_tlo_ff <= req_data.t_low;
         s1_thi_ff <= req_data.t_high;
      end
   end

   // ---------------- stage 2: products for a, hb, c ----------------
   logic signed [63:0] m_dd [3], m_od [3], m_oo [3];
   logic [61:0]        m_rr;
   logic               s2_vld_ff;
   logic signed [47:0] s2_dd_ff [3], s2_od_ff [3], s2_oo_ff [3], s2_rr_ff;
   logic signed [31:0] s2_org_ff [3], s2_dir_ff [3], s2_tlo_ff, s2_thi_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_dd[i] = s1_dir_ff[i] * s1_dir_ff[i];
         m_od[i] = s1_oc_ff[i] * s1_dir_ff[i];
         m_oo[i] = s1_oc_ff[i] * s1_oc_ff[i];
      end
      m_rr = r_eff * r_eff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s2_dd_ff[i]  <= m_dd[i][63:16];
            s2_od_ff[i]  <= m_od[i][63:16];
            s2_oo_ff[i]  <= m_oo[i][63:16];
            s2_org_ff[i] <= s1_org_ff[i];
            s2_dir_ff[i] <= s1_dir_ff[i];
         end
         s2_rr_ff  <= {2'b00, m_rr[61:16]};
         s2_tlo_ff <= s1_tlo_ff;
         s2_thi_ff <= s1_thi_ff;
      end
   end

   // ---------------- stage 3: sums ----------------
   logic               s3_vld_ff;
   logic signed [31:0] s3_a_ff, s3_hb_ff, s3_c_ff;
   logic signed [31:0] s3_org_ff [3], s3_dir_ff [3], s3_tlo_ff, s3_thi_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_a_ff  <= sat32(66'(s2_dd_ff[0]) + 66'(s2_dd_ff[1]) + 66'(s2_dd_ff[2]));
         s3_hb_ff <= sat32(66'(s2_od_ff[0]) + 66'(s2_od_ff[1]) + 66'(s2_od_ff[2]));
         s3_c_ff  <= sat32(66'(s2_oo_ff[0]) + 66'(s2_oo_ff[1]) + 66'(s2_oo_ff[2])
                           - 66'(s2_rr_ff));
         for (int i = 0; i < 3; i++) begin
            s3_org_ff[i] <= s2_org_ff[i];
            s3_dir_ff[i] <= s2_dir_ff[i];
         end
         s3_tlo_ff <= s2_tlo_ff;
         s3_thi_ff <= s2_thi_ff;
      end
   end

   // ---------------- stage 4: hb*hb and a*c ----------------
   logic signed [63:0] m_hh, m_ac;
   logic               s4_vld_ff;
   logic signed [47:0] s4_hh_ff, s4_ac_ff;
   logic signed [31:0] s4_a_ff, s4_hb_ff;
   logic signed [31:0] s4_org_ff [3], s4_dir_ff [3], s4_tlo_ff, s4_thi_ff;

   assign m_hh = s3_hb_ff * s3_hb_ff;
   assign m_ac = s3_a_ff * s3_c_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_hh_ff <= m_hh[63:16];
         s4_ac_ff <= m_ac[63:16];
         s4_a_ff  <= s3_a_ff;
         s4_hb_ff <= s3_hb_ff;
         for (int i = 0; i < 3; i++) begin
            s4_org_ff[i] <= s3_org_ff[i];
            s4_dir_ff[i] <= s3_dir_ff[i];
         end
         s4_tlo_ff <= s3_tlo_ff;
         s4_thi_ff <= s3_thi_ff;
      end
   end

   // ---------------- stage 5: discriminant ----------------
   logic signed [31:0]    disc;
   logic                  cand;
   logic                  s5_vld_ff;
   logic [SQRT_IN_W-1:0]  s5_v_ff;
   sqd_type               s5_side;
   logic                  s5_cand_ff;
   logic signed [31:0]    s5_a_ff, s5_hb_ff;
   logic signed [31:0]    s5_org_ff [3], s5_dir_ff [3], s5_tlo_ff, s5_thi_ff;

   assign disc = sat32(66'(s4_hh_ff) - 66'(s4_ac_ff));
   assign cand = (disc > 0) && (s4_a_ff > 0);

   always_ff @(posedge clock) begin
      if (en) begin
         s5_v_ff    <= cand ? {disc, 16'h0000} : '0;
         s5_cand_ff <= cand;
         s5_a_ff    <= s4_a_ff;
         s5_hb_ff   <= s4_hb_ff;
         for (int i = 0; i < 3; i++) begin
            s5_org_ff[i] <= s4_org_ff[i];
            s5_dir_ff[i] <= s4_dir_ff[i];
         end
         s5_tlo_ff <= s4_tlo_ff;
         s5_thi_ff <= s4_thi_ff;
      end
   end

   always_comb begin
      s5_side.cand = s5_cand_ff;
      s5_side.a    = s5_a_ff;
      s5_side.hb   = s5_hb_ff;
      for (int i = 0; i < 3; i++) begin
         s5_side.org[i] = s5_org_ff[i];
         s5_side.dir[i] = s5_dir_ff[i];
      end
      s5_side.tlo = s5_tlo_ff;
      s5_side.thi = s5_thi_ff;
   end

   // ---------------- square root ----------------
   logic [SQRT_OUT_W-1:0] sq_root;
   logic                  da_vld;
   sqd_type               da;

   rsi_sqrt_pipe u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (s5_v_ff),
      .root     (sq_root)
   );

   rsi_delay #(.DEPTH(SQRT_LAT), .WIDTH(SQD_W)) u_dly_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s5_vld_ff),
      .in_data  (s5_side),
      .out_vld  (da_vld),
      .out_data (da)
   );

   // ---------------- stage 6: root numerators ----------------
   logic signed [33:0]  n1, n2;
   logic [33:0]         mag1, mag2;
   logic                s6_vld_ff;
   logic [DIV_N_W-1:0]  s6_num1_ff, s6_num2_ff;
   logic [DIV_D_W-1:0]  s6_dvs_ff;
   tdd_type             s6_side_ff;

   always_comb begin
      n1   = -34'(da.hb) - $signed(34'(sq_root));
      n2   = -34'(da.hb) + $signed(34'(sq_root));
      mag1 = n1[33] ? 34'(-n1) : 34'(n1);
      mag2 = n2[33] ? 34'(-n2) : 34'(n2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_num1_ff      <= {mag1[32:0], 16'h0000};
         s6_num2_ff      <= {mag2[32:0], 16'h0000};
         s6_dvs_ff       <= da.a[DIV_D_W-1:0];
         s6_side_ff.cand <= da.cand;
         s6_side_ff.neg1 <= n1[33];
         s6_side_ff.neg2 <= n2[33];
         s6_side_ff.org  <= da.org;
         s6_side_ff.dir  <= da.dir;
         s6_side_ff.tlo  <= da.tlo;
         s6_side_ff.thi  <= da.thi;
      end
   end

   // ---------------- near and far root division ----------------
   logic [DIV_N_W-1:0] q1, q2;
   logic               db_vld;
   tdd_type            db;

   rsi_div_pipe u_div_near (
      .clock    (clock),
      .en       (en),
      .dividend (s6_num1_ff),
      .divisor  (s6_dvs_ff),
      .quotient (q1)
   );

   rsi_div_pipe u_div_far (
      .clock    (clock),
      .en       (en),
      .dividend (s6_num2_ff),
      .divisor  (s6_dvs_ff),
      .quotient (q2)
   );

   rsi_delay #(.DEPTH(DIV_LAT), .WIDTH(TDD_W)) u_dly_t (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s6_vld_ff),
      .in_data  (s6_side_ff),
      .out_vld  (db_vld),
      .out_data (db)
   );

   // ---------------- stage 7: root select ----------------
   logic signed [31:0] t1, t2;
   logic               in1, in2;
   logic               s7_vld_ff, s7_found_ff;
   logic signed [31:0] s7_t_ff;
   logic [2:0][31:0]   s7_org_ff, s7_dir_ff;

   always_comb begin
      t1  = sdiv_sat(db.neg1, q1);
      t2  = sdiv_sat(db.neg2, q2);
      in1 = (t1 < db.thi) && (t1 > db.tlo);
      in2 = (t2 < db.thi) && (t2 > db.tlo);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_found_ff <= db.cand && (in1 || in2);
         s7_t_ff     <= in1 ? t1 : t2;
         s7_org_ff   <= db.org;
         s7_dir_ff   <= db.dir;
      end
   end

   // ---------------- stage 8: t * dir ----------------
   logic signed [63:0] m_td [3];
   logic               s8_vld_ff, s8_found_ff;
   logic signed [31:0] s8_t_ff;
   logic signed [47:0] s8_td_ff [3];
   logic [2:0][31:0]   s8_org_ff, s8_dir_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_td[i] = s7_t_ff * $signed(s7_dir_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s8_td_ff[i] <= m_td[i][63:16];
         end
         s8_found_ff <= s7_found_ff;
         s8_t_ff     <= s7_t_ff;
         s8_org_ff   <= s7_org_ff;
         s8_dir_ff   <= s7_dir_ff;
      end
   end

   // ---------------- stage 9: hit point ----------------
   logic               s9_vld_ff, s9_found_ff;
   logic signed [31:0] s9_t_ff;
   logic signed [31:0] s9_pt_ff [3];
   logic [2:0][31:0]   s9_dir_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s9_pt_ff[i] <= sat32(66'($signed(s8_org_ff[i])) + 66'(sat32(66'(s8_td_ff[i]))));
         end
         s9_found_ff <= s8_found_ff;
         s9_t_ff     <= s8_t_ff;
         s9_dir_ff   <= s8_dir_ff;
      end
   end

   // ---------------- stage 10: normal numerators ----------------
   logic signed [33:0] dv [3];
   logic [33:0]        dmag [3];
   logic               s10_vld_ff;
   logic [DIV_N_W-1:0] s10_num_ff [3];
   ndd_type            s10_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv[i]   = 34'(s9_pt_ff[i]) - 34'(ctr[i]);
         dmag[i] = dv[i][33] ? 34'(-dv[i]) : 34'(dv[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s10_num_ff[i]        <= {dmag[i][32:0], 16'h0000};
            s10_side_ff.neg[i]   <= dv[i][33];
            s10_side_ff.pt[i]    <= s9_pt_ff[i];
         end
         s10_side_ff.found <= s9_found_ff;
         s10_side_ff.t     <= s9_t_ff;
         s10_side_ff.dir   <= s9_dir_ff;
      end
   end

   // ---------------- normal division by radius ----------------
   logic [DIV_N_W-1:0] qn [3];
   logic               dc_vld;
   ndd_type            dc;

   for (genvar g = 0; g < 3; g++) begin : g_ndiv
      rsi_div_pipe u_div_norm (
         .clock    (clock),
         .en       (en),
         .dividend (s10_num_ff[g]),
         .divisor  (r_eff),
         .quotient (qn[g])
      );
   end

   rsi_delay #(.DEPTH(DIV_LAT), .WIDTH(NDD_W)) u_dly_n (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s10_vld_ff),
      .in_data  (s10_side_ff),
      .out_vld  (dc_vld),
      .out_data (dc)
   );

   // ---------------- stage 11: normal and facing products ----------------
   logic signed [31:0] nrm [3];
   logic signed [63:0] m_fd [3];
   logic               s11_vld_ff, s11_found_ff;
   logic signed [31:0] s11_t_ff;
   logic signed [31:0] s11_nrm_ff [3];
   logic signed [47:0] s11_fd_ff [3];
   logic [2:0][31:0]   s11_pt_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm[i]  = sdiv_sat(dc.neg[i], qn[i]);
         m_fd[i] = $signed(dc.dir[i]) * nrm[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s11_nrm_ff[i] <= nrm[i];
            s11_fd_ff[i]  <= m_fd[i][63:16];
         end
         s11_found_ff <= dc.found;
         s11_t_ff     <= dc.t;
         s11_pt_ff    <= dc.pt;
      end
   end

   // ---------------- output register ----------------
   logic signed [65:0] facing;
   logic               front;
   logic signed [31:0] nrm_out [3];
   logic               rsp_vld_ff;
   rsp_type            rsp_data_ff;

   always_comb begin
      facing = 66'(s11_fd_ff[0]) + 66'(s11_fd_ff[1]) + 66'(s11_fd_ff[2]);
      front  = facing < 0;
      for (int i = 0; i < 3; i++) begin
         nrm_out[i] = front ? s11_nrm_ff[i] : sat32(-66'(s11_nrm_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (s11_found_ff) begin
            rsp_data_ff.hit_found    <= 1'b1;
            rsp_data_ff.hit_distance <= s11_t_ff;
            rsp_data_ff.hit_x        <= s11_pt_ff[0];
            rsp_data_ff.hit_y        <= s11_pt_ff[1];
            rsp_data_ff.hit_z        <= s11_pt_ff[2];
            rsp_data_ff.normal_x     <= nrm_out[0];
            rsp_data_ff.normal_y     <= nrm_out[1];
            rsp_data_ff.normal_z     <= nrm_out[2];
            rsp_data_ff.front_face   <= front;
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
         s11_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= da_vld;
         s7_vld_ff  <= db_vld;
         s8_vld_ff  <= s7_vld_ff;
         s9_vld_ff  <= s8_vld_ff;
         s10_vld_ff <= s9_vld_ff;
         s11_vld_ff <= dc_vld;
         rsp_vld_ff <= s11_vld_ff;
      end
   end

   // whole pipeline advances unless a finished result is held
   assign en        = !rsp_vld_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks ----------------
   `RSI_ASSERT(a_front_needs_hit, clock, reset, rsp_valid && rsp_data.front_face |-> rsp_data.hit_found, "front face flagged on a miss")
   `RSI_ASSERT(a_miss_is_zero, clock, reset, rsp_valid && !rsp_data.hit_found |-> rsp_data.hit_distance == 0 && rsp_data.hit_x == 0 && rsp_data.normal_x == 0, "miss result not cleared")
   `RSI_ASSERT(a_stall_only_when_held, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "input stalled without a held result")
   `RSI_ASSERT_NR(a_reset_clears_out, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

`default_nettype wire
